[rtl/smr_pkg.sv]
package smr_pkg;
   localparam int MAX_SEGMENTS_DEF  = 256;
   localparam int SEGMENT_WORDS_DEF = 1024;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 32;
   localparam int REQ_ID_W = 8;
   localparam int REQ_IDX_W = 10;
   localparam int REQ_LEN_W = 11;

   localparam logic [FUNC_W-1:0] FN_MAP     = 3'd0;
   localparam logic [FUNC_W-1:0] FN_UNMAP   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_LOAD    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_STORE   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_PROGRAM = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

   // back-end operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_STORE = 3'd2;
   localparam logic [2:0] OP_FILL  = 3'd3;
   localparam logic [2:0] OP_COPY  = 3'd4;

   typedef struct packed {
      logic [2:0]          op;
      logic [REQ_ID_W-1:0] seg;
      logic [10:0]         count;
      logic [REQ_IDX_W-1:0] index;
      logic [DATA_W-1:0]   wdata;
      logic [REQ_ID_W-1:0] new_id;
      logic [STATUS_W-1:0] status;
   } work_type;
endpackage

[rtl/smr_front.sv]
module smr_front #(
   parameter int MAX_SEGMENTS  = smr_pkg::MAX_SEGMENTS_DEF,
   parameter int SEGMENT_WORDS = smr_pkg::SEGMENT_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_func,
   input  logic [7:0]                  req_segment_id,
   input  logic [9:0]                  req_word_index,
   input  logic [10:0]                 req_segment_length,
   input  logic [31:0]                 req_write_data,
   output logic                        wk_valid,
   input  logic                        wk_ready,
   output smr_pkg::work_type           wk_data
);
   import smr_pkg::*;
   localparam int IDW = $clog2(MAX_SEGMENTS);
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int LW  = $clog2(SEGMENT_WORDS + 1);

   logic [LW-1:0]  size_mem [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0] mapped_ff, mapped_in;
   logic [IDW-1:0] stack_mem [MAX_SEGMENTS];
   logic [CW-1:0]  freed_ff, freed_in, fresh_ff, fresh_in;
   logic [IDW-1:0] top_id_ff;
   logic           wk_valid_ff;
   work_type       wk_ff, wk_in;
   logic           pend_ff, req_take, fire;
   logic [2:0]     func_ff;
   logic [7:0]     sid_ff;
   logic [9:0]     idx_ff;
   logic [10:0]    len_ff;
   logic [31:0]    wdat_ff;
   logic           size_we, push;
   logic [IDW-1:0] size_addr;
   logic [LW-1:0]  size_val, seg_len_ff;
   logic           id_ok, mapped0;
   logic [IDW-1:0] rid;
   logic [31:0]    seg_id32, len32;

   assign req_ready = !pend_ff;
   assign req_take  = req_valid && req_ready;
   assign fire      = pend_ff && (!wk_valid_ff || wk_ready);
   assign wk_valid  = wk_valid_ff;
   assign wk_data   = wk_ff;
   assign seg_id32  = 32'(sid_ff);
   assign len32     = 32'(len_ff);
   assign id_ok     = seg_id32 < 32'(MAX_SEGMENTS);
   assign rid       = IDW'(sid_ff);
   assign mapped0   = mapped_ff[0];

   always_comb begin
      mapped_in = mapped_ff;
      freed_in  = freed_ff;
      fresh_in  = fresh_ff;
      size_we   = 1'b0;
      size_addr = rid;
      size_val  = '0;
      push      = 1'b0;
      wk_in     = '0;
      wk_in.seg = sid_ff;
      wk_in.index = idx_ff;
      wk_in.wdata = wdat_ff;
      wk_in.op  = OP_NONE;
      wk_in.status = ST_OK;
      unique case (func_ff) inside
         FN_MAP: begin
            if (len32 > 32'(SEGMENT_WORDS)) begin
               wk_in.status = ST_TOO_LONG;
            end else if (freed_ff != '0 || 32'(fresh_ff) < 32'(MAX_SEGMENTS)) begin
               if (freed_ff != '0) begin
                  size_addr = top_id_ff;
                  freed_in  = freed_ff - CW'(1);
               end else begin
                  size_addr = IDW'(fresh_ff);
                  fresh_in  = fresh_ff + CW'(1);
               end
               size_we   = 1'b1;
               size_val  = LW'(len_ff);
               mapped_in[size_addr] = 1'b1;
               wk_in.op  = OP_FILL;
               wk_in.seg = 8'(size_addr);
               wk_in.new_id = 8'(size_addr);
            end else begin
               wk_in.status = ST_NO_ID;
            end
         end
         FN_UNMAP: begin
            if (!id_ok || !mapped_ff[rid]) begin
               wk_in.status = ST_UNMAPPED;
            end else begin
               mapped_in[rid] = 1'b0;
               size_we = 1'b1;
               if (32'(freed_ff) < 32'(MAX_SEGMENTS)) begin
                  push     = 1'b1;
                  freed_in = freed_ff + CW'(1);
               end
            end
         end
         FN_LOAD, FN_STORE: begin
            if (!id_ok || !mapped_ff[rid]) begin
               wk_in.status = ST_UNMAPPED;
            end else if (32'(idx_ff) >= 32'(seg_len_ff)) begin
               wk_in.status = ST_RANGE;
            end else begin
               wk_in.op = (func_ff == FN_LOAD) ? OP_LOAD : OP_STORE;
            end
         end
         FN_PROGRAM: begin
            if (!id_ok || !mapped_ff[rid] || !mapped0) begin
               wk_in.status = ST_UNMAPPED;
            end else if (rid != '0) begin
               size_we   = 1'b1;
               size_addr = '0;
               size_val  = seg_len_ff;
               wk_in.op  = OP_COPY;
               wk_in.count = 11'(seg_len_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire && size_we) size_mem[size_addr] <= size_val;
      if (fire && push) stack_mem[IDW'(freed_ff)] <= rid;
      if (fire) wk_ff <= wk_in;
      if (req_take) begin
         func_ff    <= req_func;
         sid_ff     <= req_segment_id;
         idx_ff     <= req_word_index;
         len_ff     <= req_segment_length;
         wdat_ff    <= req_write_data;
         seg_len_ff <= size_mem[IDW'(req_segment_id)];
         top_id_ff  <= stack_mem[IDW'(freed_ff - CW'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff   <= '0;
         freed_ff    <= '0;
         fresh_ff    <= '0;
         pend_ff     <= 1'b0;
         wk_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            mapped_ff <= mapped_in;
            freed_ff  <= freed_in;
            fresh_ff  <= fresh_in;
         end
         if (req_take) pend_ff <= 1'b1;
         else if (fire) pend_ff <= 1'b0;
         if (fire) wk_valid_ff <= 1'b1;
         else if (wk_ready) wk_valid_ff <= 1'b0;
      end
   end
endmodule

[rtl/smr_back.sv]
module smr_back #(
   parameter int MAX_SEGMENTS  = smr_pkg::MAX_SEGMENTS_DEF,
   parameter int SEGMENT_WORDS = smr_pkg::SEGMENT_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wk_valid,
   output logic              wk_ready,
   input  smr_pkg::work_type wk_data,
   output logic              rsp_valid,
   output logic [7:0]        rsp_new_segment_id,
   output logic [31:0]       rsp_read_data,
   output logic [2:0]        rsp_status
);
   import smr_pkg::*;
   localparam int IDW = $clog2(MAX_SEGMENTS);
   localparam int WW  = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
   localparam int AW  = IDW + WW;
   localparam int CNTW = $clog2(SEGMENT_WORDS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_COPY = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [31:0]    mem [MAX_SEGMENTS * SEGMENT_WORDS];
   logic [1:0]     state_ff, state_in;
   logic [CNTW-1:0] ptr_ff, ptr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [IDW-1:0] seg_ff, seg_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [WW-1:0]  rd_word_ff, rd_word_in;
   logic [31:0]    rdata_ff;
   logic [31:0]    rdout_ff;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   logic [31:0]    wdata;
   logic           rsp_in;
   logic [7:0]     nid_ff, nid_in;
   logic [2:0]     st_ff, st_in;
   logic           rv_ff, rsel_in;
   logic [WW-1:0]  ptr_w;

   assign wk_ready  = state_ff == S_IDLE;
   assign ptr_w     = WW'(ptr_ff);
   assign rsp_valid = rv_ff;
   assign rsp_new_segment_id = nid_ff;
   assign rsp_status = st_ff;
   assign rsp_read_data = rdout_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      seg_in = seg_ff;
      rd_pend_in = 1'b0;
      rd_word_in = rd_word_ff;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = {seg_ff, ptr_w};
      rsp_in = 1'b0;
      nid_in = nid_ff;
      st_in = st_ff;
      rsel_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            raddr = {IDW'(wk_data.seg), WW'(wk_data.index)};
            if (wk_valid) begin
               nid_in = wk_data.new_id;
               st_in  = wk_data.status;
               seg_in = IDW'(wk_data.seg);
               ptr_in = '0;
               cnt_in = CNTW'(wk_data.count);
               case (wk_data.op)
                  OP_LOAD: state_in = S_LOAD;
                  OP_STORE: begin
                     we = 1'b1;
                     waddr = {IDW'(wk_data.seg), WW'(wk_data.index)};
                     wdata = wk_data.wdata;
                     rsp_in = 1'b1;
                  end
                  OP_FILL: state_in = S_FILL;
                  OP_COPY: state_in = S_COPY;
                  default: rsp_in = 1'b1;
               endcase
            end
         end
         S_LOAD: begin
            rsel_in  = 1'b1;
            rsp_in   = 1'b1;
            state_in = S_IDLE;
         end
         S_FILL: begin
            we = 1'b1;
            waddr = {seg_ff, ptr_w};
            ptr_in = ptr_ff + CNTW'(1);
            if (32'(ptr_ff) == 32'(SEGMENT_WORDS - 1)) begin
               state_in = S_IDLE;
               rsp_in = 1'b1;
            end
         end
         S_COPY: begin
            // read word ptr now, write it in the next cycle
            rd_pend_in = 1'b1;
            rd_word_in = ptr_w;
            we = rd_pend_ff;
            waddr = {IDW'(0), rd_word_ff};
            wdata = (32'(rd_word_ff) < 32'(cnt_ff)) ? rdata_ff : 32'd0;
            ptr_in = ptr_ff + CNTW'(1);
            if (rd_pend_ff && 32'(rd_word_ff) == 32'(SEGMENT_WORDS - 1)) begin
               rd_pend_in = 1'b0;
               state_in = S_IDLE;
               rsp_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff   <= mem[raddr];
      rdout_ff   <= rsel_in ? rdata_ff : 32'd0;
      rd_word_ff <= rd_word_in;
      seg_ff     <= seg_in;
      cnt_ff     <= cnt_in;
      nid_ff     <= nid_in;
      st_ff      <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ptr_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         rd_pend_ff <= rd_pend_in;
         rv_ff      <= rsp_in;
      end
   end
endmodule

[rtl/segmented_memory_with_id_recycling.sv]
// Map zero-fills the segment; load program copies the segment into segment 0 word by word,
// zeroing the words past its length. A new beat is taken once the front end has handed the
// last one on; map and load program hold the back end for their walk.
// Synchronous reset clears ids, valid bits and queue; word memory is not cleared.
// The receiver cannot stall; results are strobed for one cycle.
module segmented_memory_with_id_recycling #(
   parameter int MAX_SEGMENTS  = smr_pkg::MAX_SEGMENTS_DEF,
   parameter int SEGMENT_WORDS = smr_pkg::SEGMENT_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_segment_id,
   input  logic [9:0]  req_word_index,
   input  logic [10:0] req_segment_length,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_new_segment_id,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_status
);
   import smr_pkg::*;
   logic     ready, wk_valid, wk_ready;
   work_type wk_data;

   assign busy = !ready;

   smr_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEGMENT_WORDS(SEGMENT_WORDS)) u_front (
      .clock(clock), .reset(reset), .req_valid(start), .req_ready(ready),
      .req_func(req_func), .req_segment_id(req_segment_id),
      .req_word_index(req_word_index), .req_segment_length(req_segment_length),
      .req_write_data(req_write_data), .wk_valid(wk_valid), .wk_ready(wk_ready),
      .wk_data(wk_data)
   );

   smr_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEGMENT_WORDS(SEGMENT_WORDS)) u_back (
      .clock(clock), .reset(reset), .wk_valid(wk_valid), .wk_ready(wk_ready),
      .wk_data(wk_data), .rsp_valid(rsp_valid),
      .rsp_new_segment_id(rsp_new_segment_id), .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status)
   );
endmodule

[rtl/smr_checker.sv]
module smr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_new_segment_id,
   input logic [31:0] rsp_read_data,
   input logic [2:0]  rsp_status
);
   import smr_pkg::*;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_RANGE) else $error("bad status");
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_data == 32'd0 &&
      rsp_new_segment_id == 8'd0) else $error("data on error");
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_data == 32'd0 || rsp_new_segment_id == 8'd0)
      else $error("two payloads");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result after reset");
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after beat");
endmodule

bind segmented_memory_with_id_recycling smr_checker u_smr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_new_segment_id(rsp_new_segment_id),
   .rsp_read_data(rsp_read_data), .rsp_status(rsp_status)
);
